### rtl/dary_max_heap_queue_macros.svh
// ============================================================================
// dary_max_heap_queue_macros.svh
// Assertion macros shared by the heap queue checker.
// ============================================================================
`ifndef DARY_MAX_HEAP_QUEUE_MACROS_SVH
`define DARY_MAX_HEAP_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DHQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DHQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`endif

### rtl/dhq_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// dhq_pkg
// Shared constants, entry and control types for the d-ary heap queue.
// ============================================================================
package dhq_pkg;

    localparam int CAPACITY  = 256;
    localparam int ARITY     = 2;
    localparam int PRIO_W    = 16;
    localparam int TAG_W     = 32;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CHILD_W   = $clog2(CAPACITY * ARITY + 1);
    localparam int K_W       = $clog2(ARITY + 1);
    // Parent index by reciprocal multiplication; exact for every index below CAPACITY.
    localparam int DIV_SHIFT = IDX_W + $clog2(ARITY);
    localparam int DIV_MULT  = ((2 ** DIV_SHIFT) + ARITY - 1) / ARITY;
    localparam int PROD_W    = IDX_W + DIV_SHIFT;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_DELETE = 1'b1
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_DIV,
        ST_UP_READ,
        ST_UP_CMP,
        ST_DEL_ROOT,
        ST_DEL_LAST,
        ST_DEL_LOAD,
        ST_DN_START,
        ST_DN_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    typedef struct packed {
        status_t          status;
        entry_t           removed;
        logic [CNT_W-1:0] count;
    } result_t;

endpackage

### rtl/dhq_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// dhq_ram
// Heap entry store: one write port, one read port, registered read data.
// ============================================================================
module dhq_ram
(
    input  logic              clk,
    input  dhq_pkg::mem_req_t req,
    output dhq_pkg::entry_t   rd_data
);

    dhq_pkg::entry_t mem [dhq_pkg::CAPACITY];
    dhq_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/dhq_parent.sv
`timescale 1ns / 1ps
// ============================================================================
// dhq_parent
// Parent index of a heap node, (pos - 1) / ARITY, by reciprocal multiply.
// ============================================================================
module dhq_parent
(
    input  logic [dhq_pkg::IDX_W-1:0] pos,
    output logic [dhq_pkg::IDX_W-1:0] parent
);

    logic [dhq_pkg::IDX_W-1:0]  pos_m1;
    logic [dhq_pkg::PROD_W-1:0] prod;

    assign pos_m1 = pos - dhq_pkg::IDX_W'(1);
    assign prod   = dhq_pkg::PROD_W'(pos_m1) * dhq_pkg::PROD_W'(dhq_pkg::DIV_MULT);
    assign parent = prod[dhq_pkg::DIV_SHIFT +: dhq_pkg::IDX_W];

endmodule

### rtl/dhq_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// dhq_ctrl
// Request sequencer: sift-up for inserts, root removal and sift-down for
// deletes, all through the entry store with one read port and one write port.
// ============================================================================
module dhq_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       req_type,
    input  logic [dhq_pkg::PRIO_W-1:0] priority_req,
    input  logic [dhq_pkg::TAG_W-1:0]  payload,
    output logic                       res_valid,
    input  logic                       res_ready,
    output dhq_pkg::result_t           res,
    output dhq_pkg::mem_req_t          mem_req,
    input  dhq_pkg::entry_t            rd_data
);

    dhq_pkg::state_t                state_reg, state_next;
    logic [dhq_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    dhq_pkg::status_t               status_reg, status_next;
    dhq_pkg::entry_t                removed_reg, removed_next;
    dhq_pkg::entry_t                item_reg, item_next;
    dhq_pkg::entry_t                best_reg, best_next;
    logic [dhq_pkg::IDX_W-1:0]      pos_reg, pos_next;
    logic [dhq_pkg::IDX_W-1:0]      par_reg, par_next;
    logic [dhq_pkg::IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [dhq_pkg::IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [dhq_pkg::CHILD_W-1:0]    child_reg, child_next;
    logic [dhq_pkg::K_W-1:0]        k_reg, k_next;
    logic                           found_reg, found_next;
    logic                           pend_reg, pend_next;
    logic [dhq_pkg::IDX_W-1:0]      parent;
    logic                           issue;

    dhq_parent u_parent
    (
        .pos    (pos_reg),
        .parent (parent)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dhq_pkg::ST_IDLE;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            pend_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            pend_reg  <= pend_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        removed_reg  <= removed_next;
        item_reg     <= item_next;
        best_reg     <= best_next;
        pos_reg      <= pos_next;
        par_reg      <= par_next;
        best_idx_reg <= best_idx_next;
        pend_idx_reg <= pend_idx_next;
        child_reg    <= child_next;
    end

    // A child read is issued while children remain in this group and in the heap.
    assign issue = (k_reg < dhq_pkg::K_W'(dhq_pkg::ARITY)) &&
                   (child_reg < dhq_pkg::CHILD_W'(cnt_reg));

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        status_next   = status_reg;
        removed_next  = removed_reg;
        item_next     = item_reg;
        best_next     = best_reg;
        pos_next      = pos_reg;
        par_next      = par_reg;
        best_idx_next = best_idx_reg;
        pend_idx_next = pend_idx_reg;
        child_next    = child_reg;
        k_next        = k_reg;
        found_next    = found_reg;
        pend_next     = pend_reg;
        mem_req       = '0;
        in_ready      = 1'b0;
        res_valid     = 1'b0;

        unique case (state_reg)
            dhq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    status_next  = dhq_pkg::STATUS_OK;
                    removed_next = '0;
                    if (req_type == dhq_pkg::REQ_INSERT)
                    begin
                        if (cnt_reg == dhq_pkg::CNT_W'(dhq_pkg::CAPACITY))
                        begin
                            status_next = dhq_pkg::STATUS_FULL;
                            state_next  = dhq_pkg::ST_FINISH;
                        end
                        else
                        begin
                            item_next.prio = priority_req;
                            item_next.tag  = payload;
                            pos_next       = cnt_reg[dhq_pkg::IDX_W-1:0];
                            cnt_next       = cnt_reg + dhq_pkg::CNT_W'(1);
                            state_next     = dhq_pkg::ST_UP_DIV;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = dhq_pkg::STATUS_EMPTY;
                            state_next  = dhq_pkg::ST_FINISH;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg - dhq_pkg::CNT_W'(1);
                            state_next = dhq_pkg::ST_DEL_ROOT;
                        end
                    end
                end
            end

            dhq_pkg::ST_UP_DIV:
            begin
                if (pos_reg == '0)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pos_reg;
                    mem_req.wr_data = item_reg;
                    state_next      = dhq_pkg::ST_FINISH;
                end
                else
                begin
                    par_next   = parent;
                    state_next = dhq_pkg::ST_UP_READ;
                end
            end

            dhq_pkg::ST_UP_READ:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = par_reg;
                state_next      = dhq_pkg::ST_UP_CMP;
            end

            dhq_pkg::ST_UP_CMP:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg;
                if (item_reg.prio <= rd_data.prio)
                begin
                    mem_req.wr_data = item_reg;
                    state_next      = dhq_pkg::ST_FINISH;
                end
                else
                begin
                    // The parent moves down into the hole and the hole climbs.
                    mem_req.wr_data = rd_data;
                    pos_next        = par_reg;
                    state_next      = dhq_pkg::ST_UP_DIV;
                end
            end

            dhq_pkg::ST_DEL_ROOT:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                state_next      = dhq_pkg::ST_DEL_LAST;
            end

            dhq_pkg::ST_DEL_LAST:
            begin
                removed_next    = rd_data;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = cnt_reg[dhq_pkg::IDX_W-1:0];
                state_next      = dhq_pkg::ST_DEL_LOAD;
            end

            dhq_pkg::ST_DEL_LOAD:
            begin
                item_next = rd_data;
                pos_next  = '0;
                if (cnt_reg == '0)
                begin
                    state_next = dhq_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = dhq_pkg::ST_DN_START;
                end
            end

            dhq_pkg::ST_DN_START:
            begin
                child_next = dhq_pkg::CHILD_W'(pos_reg) * dhq_pkg::CHILD_W'(dhq_pkg::ARITY)
                             + dhq_pkg::CHILD_W'(1);
                k_next     = '0;
                found_next = 1'b0;
                pend_next  = 1'b0;
                state_next = dhq_pkg::ST_DN_SCAN;
            end

            dhq_pkg::ST_DN_SCAN:
            begin
                // Fold in the child read issued last cycle; ties keep the lower index.
                if (pend_reg && (!found_reg || (rd_data.prio > best_reg.prio)))
                begin
                    best_next     = rd_data;
                    best_idx_next = pend_idx_reg;
                    found_next    = 1'b1;
                end
                if (issue)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = child_reg[dhq_pkg::IDX_W-1:0];
                    pend_idx_next   = child_reg[dhq_pkg::IDX_W-1:0];
                    child_next      = child_reg + dhq_pkg::CHILD_W'(1);
                    k_next          = k_reg + dhq_pkg::K_W'(1);
                    pend_next       = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = pos_reg;
                        if (!found_reg || (item_reg.prio >= best_reg.prio))
                        begin
                            mem_req.wr_data = item_reg;
                            state_next      = dhq_pkg::ST_FINISH;
                        end
                        else
                        begin
                            mem_req.wr_data = best_reg;
                            pos_next        = best_idx_reg;
                            state_next      = dhq_pkg::ST_DN_START;
                        end
                    end
                end
            end

            dhq_pkg::ST_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = dhq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dhq_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.status  = status_reg;
    assign res.removed = removed_reg;
    assign res.count   = cnt_reg;

endmodule

### rtl/dary_max_heap_queue.sv
`timescale 1ns / 1ps
// An insert climbs the heap one level at a time until it stops or reaches the root; a
// delete-max swaps down one level at a time, scanning up to ARITY children per level, until
// it stops; a full or empty report goes straight to the result. Only one request is in work
// at a time; the next beat can be taken in the cycle after the result enters the output
// register. Reset clears the count, the sequencer and the output beat only.
// ============================================================================
// dary_max_heap_queue
// Max-priority queue kept as a d-ary heap in a synchronous entry store.
// ============================================================================
module dary_max_heap_queue
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       req_type,
    input  logic [dhq_pkg::PRIO_W-1:0] priority_req,
    input  logic [dhq_pkg::TAG_W-1:0]  payload,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic [dhq_pkg::PRIO_W-1:0] out_priority,
    output logic [dhq_pkg::TAG_W-1:0]  out_payload,
    output logic [dhq_pkg::CNT_W-1:0]  count
);

    // The sequencer hands one result to the output register. Because the
    // register frees the sequencer, a new request beat can be accepted while
    // the previous result beat is still waiting for the consumer.
    // Each heap level takes several store accesses because the store gives one read per
    // cycle with registered read data. The entry store is never cleared,
    // since only entries below the count are ever read.
    dhq_pkg::mem_req_t mem_req;
    dhq_pkg::entry_t   rd_data;
    dhq_pkg::result_t  res;
    logic              res_valid;
    logic              res_ready;
    logic              out_valid_reg, out_valid_next;
    dhq_pkg::result_t  out_reg;

    dhq_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .priority_req (priority_req),
        .payload      (payload),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_req      (mem_req),
        .rd_data      (rd_data)
    );

    // The whole heap lives in this store; the sequencer reads, modifies and
    // writes it back, at most one entry read and one entry written per cycle.
    dhq_ram u_ram
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // The output register takes a new result when it is empty or being drained.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign out_priority = out_reg.removed.prio;
    assign out_payload  = out_reg.removed.tag;
    assign count        = out_reg.count;

endmodule

### rtl/dhq_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// dhq_checker
// Port-level checks for the heap queue, bound to the top level.
// ============================================================================
`include "dary_max_heap_queue_macros.svh"

module dhq_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [1:0]                 status,
    input logic [dhq_pkg::PRIO_W-1:0] out_priority,
    input logic [dhq_pkg::TAG_W-1:0]  out_payload,
    input logic [dhq_pkg::CNT_W-1:0]  count
);

    // A full report only happens when the queue holds its whole capacity.
    `DHQ_ASSERT_NOW(a_full_count, out_valid && (status == dhq_pkg::STATUS_FULL), count == dhq_pkg::CNT_W'(dhq_pkg::CAPACITY))

    // An empty report leaves an empty queue and carries no entry.
    `DHQ_ASSERT_NOW(a_empty_zero, out_valid && (status == dhq_pkg::STATUS_EMPTY), (count == '0) && (out_priority == '0) && (out_payload == '0))

    // One request at a time: an accepted beat drops ready on the next cycle.
    `DHQ_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready)

    // A stalled result beat holds.
    `DHQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(count) && $stable(out_payload))

endmodule

bind dary_max_heap_queue dhq_checker u_dhq_checker (.*);
